// ===== sv/wmr2_pkg.sv =====
// Shared types, constants and micro-op table for the windowed mean r squared block.
// No dependencies; used by the interfaces, controller, datapath and top level.
package wmr2_pkg;

   localparam int MAX_LOCI = 64;
   localparam int MAX_INDIVIDUALS = 256;
   localparam int ROW_W = $clog2(MAX_LOCI);
   localparam int IND_W = $clog2(MAX_INDIVIDUALS);
   localparam int ADDR_W = ROW_W + IND_W;
   localparam int CNT_W = ROW_W + 1;
   localparam int IDX_W = IND_W + 1;
   localparam int GENO_W = 16;
   localparam int SUM_W = 24;
   localparam int SQ_W = 40;
   localparam int SXY_W = 40;
   localparam int OPD_W = 24;
   localparam int PROD_W = 2 * OPD_W;
   localparam int V_W = 48;
   localparam int ACC_W = 96;
   localparam int TOT_W = 28;
   localparam int Q_W = 17;
   localparam int PAIRS_W = 11;
   localparam int STEP_W = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [GENO_W-1:0] GENO_MAX = 16'd32768;
   localparam logic [CNT_W-1:0] MIN_SNPS = CNT_W'(4);
   localparam logic [Q_W-1:0] ONE_Q16 = 17'd65536;
   localparam logic [IDX_W-1:0] N_CAP = IDX_W'(MAX_INDIVIDUALS);
   localparam logic [CNT_W-1:0] LOCI_CAP = CNT_W'(MAX_LOCI);

   localparam logic [31:0] RST_WINDOW_START = 32'd0;
   localparam logic [24:0] RST_WINDOW_SIZE = 25'd10000;
   localparam logic [8:0] RST_NUM_IND = 9'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_IND = 2'd2;

   localparam logic [STEP_W-1:0] UOP_A_FIRST = 5'd0;
   localparam logic [STEP_W-1:0] UOP_A_LAST = 5'd12;
   localparam logic [STEP_W-1:0] UOP_B_FIRST = 5'd13;
   localparam logic [STEP_W-1:0] UOP_B_LAST = 5'd23;
   localparam logic [STEP_W-1:0] R2_ITER_LAST = 5'd15;
   localparam logic [STEP_W-1:0] MEAN_ITER_LAST = 5'd27;

   typedef enum logic [3:0] {
      ST_LOAD, ST_FILL, ST_CSTART, ST_PAIR, ST_SXY, ST_SXY_WAIT, ST_UOP_A, ST_CHK_V,
      ST_UOP_B, ST_CHK_Q, ST_DIV, ST_ADDQ, ST_NEXT, ST_MEAN, ST_MEAN_DIV, ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OPD_ZERO, OPD_N, OPD_SXX_LO, OPD_SXX_HI, OPD_SYY_LO, OPD_SYY_HI, OPD_SXY_LO,
      OPD_SXY_HI, OPD_SA, OPD_SB, OPD_CM_LO, OPD_CM_HI, OPD_VX_LO, OPD_VX_HI,
      OPD_VY_LO, OPD_VY_HI
   } opd_type;

   typedef enum logic [2:0] {
      DST_NONE, DST_VX, DST_VY, DST_CM, DST_NUM, DST_DEN
   } dst_type;

   typedef enum logic [1:0] {
      SH_0, SH_24, SH_48
   } shift_type;

   typedef struct packed {
      logic      mul;
      logic      clr;
      logic      sub;
      shift_type sh;
      opd_type   opa;
      opd_type   opb;
      dst_type   dst;
   } uop_type;

   typedef struct packed {
      logic             cur_upd;
      logic             row_start;
      logic             item_go;
      logic             fill_go;
      logic             commit;
      logic [ROW_W-1:0] wr_row;
      logic [IND_W-1:0] wr_idx;
      logic             rd_go;
      logic [ROW_W-1:0] rd_a;
      logic [ROW_W-1:0] rd_b;
      logic [IND_W-1:0] rd_idx;
      logic             sxy_clr;
      logic             uop_go;
      uop_type          uop;
      logic             tot_clr;
      logic             tot_add_one;
      logic             tot_add_q;
      logic             div_r2_start;
      logic             div_mean_start;
      logic             div_step;
      logic             pairs_load;
      logic [CNT_W-1:0] snp;
      logic             out_load;
      logic             out_win;
      logic             out_deg;
      logic             out_ovf;
   } cmd_type;

   typedef struct packed {
      logic             in_window;
      logic             sxy_busy;
      logic             v_bad;
      logic             num_ge_den;
      logic [IDX_W-1:0] n_eff;
   } stat_type;

   function automatic uop_type mk_uop(input logic mul, input logic clr, input logic sub,
                                      input shift_type sh, input opd_type opa,
                                      input opd_type opb, input dst_type dst);
      uop_type u;
      u.mul = mul;
      u.clr = clr;
      u.sub = sub;
      u.sh = sh;
      u.opa = opa;
      u.opb = opb;
      u.dst = dst;
      return u;
   endfunction

   // variances and covariance, then numerator and denominator of r squared
   function automatic uop_type uop_at(input logic [STEP_W-1:0] step);
      uop_type u;
      unique case (step)
         5'd0:  u = mk_uop(1'b1, 1'b1, 1'b0, SH_0,  OPD_N,     OPD_SXX_LO, DST_NONE);
         5'd1:  u = mk_uop(1'b1, 1'b0, 1'b0, SH_24, OPD_N,     OPD_SXX_HI, DST_NONE);
         5'd2:  u = mk_uop(1'b1, 1'b0, 1'b1, SH_0,  OPD_SA,    OPD_SA,     DST_NONE);
         5'd3:  u = mk_uop(1'b0, 1'b0, 1'b0, SH_0,  OPD_ZERO,  OPD_ZERO,   DST_VX);
         5'd4:  u = mk_uop(1'b1, 1'b1, 1'b0, SH_0,  OPD_N,     OPD_SYY_LO, DST_NONE);
         5'd5:  u = mk_uop(1'b1, 1'b0, 1'b0, SH_24, OPD_N,     OPD_SYY_HI, DST_NONE);
         5'd6:  u = mk_uop(1'b1, 1'b0, 1'b1, SH_0,  OPD_SB,    OPD_SB,     DST_NONE);
         5'd7:  u = mk_uop(1'b0, 1'b0, 1'b0, SH_0,  OPD_ZERO,  OPD_ZERO,   DST_VY);
         5'd8:  u = mk_uop(1'b1, 1'b1, 1'b0, SH_0,  OPD_N,     OPD_SXY_LO, DST_NONE);
         5'd9:  u = mk_uop(1'b1, 1'b0, 1'b0, SH_24, OPD_N,     OPD_SXY_HI, DST_NONE);
         5'd10: u = mk_uop(1'b1, 1'b0, 1'b1, SH_0,  OPD_SA,    OPD_SB,     DST_NONE);
         5'd11: u = mk_uop(1'b0, 1'b0, 1'b0, SH_0,  OPD_ZERO,  OPD_ZERO,   DST_CM);
         5'd13: u = mk_uop(1'b1, 1'b1, 1'b0, SH_0,  OPD_CM_LO, OPD_CM_LO,  DST_NONE);
         5'd14: u = mk_uop(1'b1, 1'b0, 1'b0, SH_24, OPD_CM_LO, OPD_CM_HI,  DST_NONE);
         5'd15: u = mk_uop(1'b1, 1'b0, 1'b0, SH_24, OPD_CM_LO, OPD_CM_HI,  DST_NONE);
         5'd16: u = mk_uop(1'b1, 1'b0, 1'b0, SH_48, OPD_CM_HI, OPD_CM_HI,  DST_NONE);
         5'd17: u = mk_uop(1'b0, 1'b0, 1'b0, SH_0,  OPD_ZERO,  OPD_ZERO,   DST_NUM);
         5'd18: u = mk_uop(1'b1, 1'b1, 1'b0, SH_0,  OPD_VX_LO, OPD_VY_LO,  DST_NONE);
         5'd19: u = mk_uop(1'b1, 1'b0, 1'b0, SH_24, OPD_VX_LO, OPD_VY_HI,  DST_NONE);
         5'd20: u = mk_uop(1'b1, 1'b0, 1'b0, SH_24, OPD_VX_HI, OPD_VY_LO,  DST_NONE);
         5'd21: u = mk_uop(1'b1, 1'b0, 1'b0, SH_48, OPD_VX_HI, OPD_VY_HI,  DST_NONE);
         5'd22: u = mk_uop(1'b0, 1'b0, 1'b0, SH_0,  OPD_ZERO,  OPD_ZERO,   DST_DEN);
         default: u = mk_uop(1'b0, 1'b0, 1'b0, SH_0, OPD_ZERO, OPD_ZERO, DST_NONE);
      endcase
      return u;
   endfunction

endpackage

// ===== sv/wmr2_if.sv =====
// Valid/ready channel interfaces for genotype input and result output.
// Depends on wmr2_pkg for field widths.
interface wmr2_req_if import wmr2_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [31:0]       locus_position;
   logic [GENO_W-1:0] genotype_value;
   logic              last_of_locus;
   logic              last_of_set;

   modport source (output valid, locus_position, genotype_value, last_of_locus, last_of_set,
                   input ready);
   modport sink (input valid, locus_position, genotype_value, last_of_locus, last_of_set,
                 output ready);
endinterface

interface wmr2_rsp_if import wmr2_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             window_valid;
   logic [CNT_W-1:0] snp_count;
   logic [Q_W-1:0]   mean_r_squared;
   logic             degenerate_pair;
   logic             locus_overflow;

   modport source (output valid, window_valid, snp_count, mean_r_squared, degenerate_pair,
                   locus_overflow, input ready);
   modport sink (input valid, window_valid, snp_count, mean_r_squared, degenerate_pair,
                 locus_overflow, output ready);
endinterface

// ===== sv/wmr2_ctrl.sv =====
// Controller: load sequencing, pair loop, micro-op sequencing and result handshake.
// Depends on wmr2_pkg; drives the datapath through cmd_type, reads stat_type.
module wmr2_ctrl import wmr2_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     req_last_of_locus,
   input  logic     req_last_of_set,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output cmd_type  cmd,
   input  stat_type stat
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  stored_ff, stored_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]  ri_ff, ri_in;
   logic [ROW_W-1:0]  pa_ff, pa_in, pb_ff, pb_in;
   logic [STEP_W-1:0] step_ff, step_in, cnt_ff, cnt_in;
   logic              open_ff, open_in, ovf_ff, ovf_in, pend_ff, pend_in, deg_ff, deg_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic             accept, first, open_now, close;
   logic [IDX_W-1:0] idx_inc;
   logic [CNT_W-1:0] s_m1, s_m2;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         stored_ff    <= '0;
         idx_ff       <= '0;
         fill_ff      <= '0;
         ri_ff        <= '0;
         pa_ff        <= '0;
         pb_ff        <= '0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         open_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         deg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stored_ff    <= stored_in;
         idx_ff       <= idx_in;
         fill_ff      <= fill_in;
         ri_ff        <= ri_in;
         pa_ff        <= pa_in;
         pb_ff        <= pb_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         open_ff      <= open_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         deg_ff       <= deg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign first     = (idx_ff == '0);
   assign open_now  = first ? (stat.in_window && (stored_ff < LOCI_CAP)) : open_ff;
   assign close     = req_last_of_locus || req_last_of_set;
   assign idx_inc   = (idx_ff < N_CAP) ? idx_ff + 1'b1 : idx_ff;
   assign s_m1      = stored_ff - 1'b1;
   assign s_m2      = stored_ff - CNT_W'(2);

   always_comb begin
      state_in     = state_ff;
      stored_in    = stored_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      ri_in        = ri_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      open_in      = open_ff;
      ovf_in       = ovf_ff;
      pend_in      = pend_ff;
      deg_in       = deg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      cmd         = '0;
      cmd.wr_row  = stored_ff[ROW_W-1:0];
      cmd.wr_idx  = idx_ff[IND_W-1:0];
      cmd.rd_a    = pa_ff;
      cmd.rd_b    = pb_ff;
      cmd.rd_idx  = ri_ff[IND_W-1:0];
      cmd.uop     = uop_at(step_ff);
      cmd.snp     = stored_ff;
      cmd.out_win = (stored_ff > MIN_SNPS);
      cmd.out_deg = (stored_ff > MIN_SNPS) && deg_ff;
      cmd.out_ovf = ovf_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               cmd.cur_upd   = 1'b1;
               cmd.row_start = first;
               cmd.item_go   = open_now && (idx_ff < stat.n_eff);
               if (first) begin
                  open_in = open_now;
                  if (stat.in_window && !(stored_ff < LOCI_CAP)) begin
                     ovf_in = 1'b1;
                  end
               end
               idx_in = idx_inc;
               if (close) begin
                  idx_in  = '0;
                  open_in = 1'b0;
                  if (open_now && (idx_inc < stat.n_eff)) begin
                     fill_in  = idx_inc;
                     pend_in  = req_last_of_set;
                     state_in = ST_FILL;
                  end else begin
                     if (open_now) begin
                        cmd.commit = 1'b1;
                        stored_in  = stored_ff + 1'b1;
                     end
                     if (req_last_of_set) begin
                        state_in = ST_CSTART;
                     end
                  end
               end
            end
         end
         ST_FILL: begin
            cmd.fill_go = 1'b1;
            cmd.wr_idx  = fill_ff[IND_W-1:0];
            fill_in     = fill_ff + 1'b1;
            if (fill_in >= stat.n_eff) begin
               cmd.commit = 1'b1;
               stored_in  = stored_ff + 1'b1;
               state_in   = pend_ff ? ST_CSTART : ST_LOAD;
            end
         end
         ST_CSTART: begin
            deg_in = 1'b0;
            if (stored_ff > MIN_SNPS) begin
               cmd.tot_clr    = 1'b1;
               cmd.pairs_load = 1'b1;
               pa_in          = '0;
               pb_in          = ROW_W'(1);
               state_in       = ST_PAIR;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_PAIR: begin
            cmd.sxy_clr = 1'b1;
            ri_in       = '0;
            state_in    = ST_SXY;
         end
         ST_SXY: begin
            if (ri_ff < stat.n_eff) begin
               cmd.rd_go = 1'b1;
               ri_in     = ri_ff + 1'b1;
            end else begin
               state_in = ST_SXY_WAIT;
            end
         end
         ST_SXY_WAIT: begin
            if (!stat.sxy_busy) begin
               step_in  = UOP_A_FIRST;
               state_in = ST_UOP_A;
            end
         end
         ST_UOP_A: begin
            cmd.uop_go = 1'b1;
            step_in    = step_ff + 1'b1;
            if (step_ff == UOP_A_LAST) begin
               state_in = ST_CHK_V;
            end
         end
         ST_CHK_V: begin
            if (stat.v_bad) begin
               deg_in   = 1'b1;
               state_in = ST_NEXT;
            end else begin
               step_in  = UOP_B_FIRST;
               state_in = ST_UOP_B;
            end
         end
         ST_UOP_B: begin
            cmd.uop_go = 1'b1;
            step_in    = step_ff + 1'b1;
            if (step_ff == UOP_B_LAST) begin
               state_in = ST_CHK_Q;
            end
         end
         ST_CHK_Q: begin
            if (stat.num_ge_den) begin
               cmd.tot_add_one = 1'b1;
               state_in        = ST_NEXT;
            end else begin
               cmd.div_r2_start = 1'b1;
               cnt_in           = '0;
               state_in         = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == R2_ITER_LAST) begin
               state_in = ST_ADDQ;
            end
         end
         ST_ADDQ: begin
            cmd.tot_add_q = 1'b1;
            state_in      = ST_NEXT;
         end
         ST_NEXT: begin
            if ({1'b0, pb_ff} == s_m1) begin
               if ({1'b0, pa_ff} == s_m2) begin
                  state_in = ST_MEAN;
               end else begin
                  pa_in    = pa_ff + 1'b1;
                  pb_in    = pa_ff + ROW_W'(2);
                  state_in = ST_PAIR;
               end
            end else begin
               pb_in    = pb_ff + 1'b1;
               state_in = ST_PAIR;
            end
         end
         ST_MEAN: begin
            cmd.div_mean_start = 1'b1;
            cnt_in             = '0;
            state_in           = ST_MEAN_DIV;
         end
         ST_MEAN_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == MEAN_ITER_LAST) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               stored_in    = '0;
               ovf_in       = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

// ===== sv/wmr2_dp.sv =====
// Datapath: config registers, genotype and row-sum memories, pair arithmetic,
// shared divider and result register. Depends on wmr2_pkg; commanded by wmr2_ctrl.
module wmr2_dp import wmr2_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [31:0]           locus_position,
   input  logic [GENO_W-1:0]     genotype_value,
   input  cmd_type               cmd,
   output stat_type              stat,
   output logic                  window_valid,
   output logic [CNT_W-1:0]      snp_count,
   output logic [Q_W-1:0]        mean_r_squared,
   output logic                  degenerate_pair,
   output logic                  locus_overflow
);

   logic [31:0] ws_ff;
   logic [24:0] wsz_ff;
   logic [8:0]  nind_ff;

   logic [GENO_W-1:0] geno_mem [2**ADDR_W];
   logic [SUM_W-1:0]  sum_mem [MAX_LOCI];
   logic [SQ_W-1:0]   sq_mem [MAX_LOCI];

   logic [GENO_W-1:0] rda_ff, rdb_ff;
   logic [SUM_W-1:0]  sa_ff, sb_ff;
   logic [SQ_W-1:0]   saa_ff, sbb_ff;
   logic              v1_ff, v2_ff;
   logic [31:0]       pxy_ff;
   logic [SXY_W-1:0]  sxy_ff;
   logic [SUM_W-1:0]  cur_sum_ff, sum_upd;
   logic [SQ_W-1:0]   cur_sq_ff, sq_upd;

   logic [PROD_W-1:0] prod_ff;
   uop_type           uop_d_ff;
   logic              uop_v_ff;
   logic [ACC_W-1:0]  acc_ff, acc_base, prod_sh;
   logic [V_W-1:0]    vx_ff, vy_ff, cm_ff;
   logic [ACC_W-1:0]  num_ff, den_ff;

   logic [ACC_W-1:0]   rem_ff, dvd_ff, dsr_ff, trial;
   logic [Q_W-1:0]     quo_ff;
   logic [TOT_W-1:0]   tot_ff;
   logic [PAIRS_W-1:0] pairs_ff;
   logic [2*CNT_W-1:0] s_prod;

   logic [GENO_W-1:0] g_sat;
   logic [31:0]       g_sq;
   logic [IDX_W-1:0]  n_eff;
   logic [OPD_W-1:0]  opa, opb;

   function automatic logic [OPD_W-1:0] pick(input opd_type sel, input logic [IDX_W-1:0] n,
                                             input logic [SQ_W-1:0] sxx,
                                             input logic [SQ_W-1:0] syy,
                                             input logic [SXY_W-1:0] sxy,
                                             input logic [SUM_W-1:0] sa,
                                             input logic [SUM_W-1:0] sb,
                                             input logic [V_W-1:0] cm,
                                             input logic [V_W-1:0] vx,
                                             input logic [V_W-1:0] vy);
      logic [OPD_W-1:0] r;
      case (sel)
         OPD_N:      r = OPD_W'(n);
         OPD_SXX_LO: r = sxx[OPD_W-1:0];
         OPD_SXX_HI: r = OPD_W'(sxx[SQ_W-1:OPD_W]);
         OPD_SYY_LO: r = syy[OPD_W-1:0];
         OPD_SYY_HI: r = OPD_W'(syy[SQ_W-1:OPD_W]);
         OPD_SXY_LO: r = sxy[OPD_W-1:0];
         OPD_SXY_HI: r = OPD_W'(sxy[SXY_W-1:OPD_W]);
         OPD_SA:     r = sa;
         OPD_SB:     r = sb;
         OPD_CM_LO:  r = cm[OPD_W-1:0];
         OPD_CM_HI:  r = cm[V_W-1:OPD_W];
         OPD_VX_LO:  r = vx[OPD_W-1:0];
         OPD_VX_HI:  r = vx[V_W-1:OPD_W];
         OPD_VY_LO:  r = vy[OPD_W-1:0];
         OPD_VY_HI:  r = vy[V_W-1:OPD_W];
         default:    r = '0;
      endcase
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff   <= RST_WINDOW_START;
         wsz_ff  <= RST_WINDOW_SIZE;
         nind_ff <= RST_NUM_IND;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WINDOW_START: ws_ff   <= csr_data;
            CSR_WINDOW_SIZE:  wsz_ff  <= csr_data[24:0];
            CSR_NUM_IND:      nind_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   assign n_eff = (nind_ff > N_CAP) ? N_CAP : nind_ff;
   assign g_sat = (genotype_value > GENO_MAX) ? GENO_MAX : genotype_value;
   assign g_sq  = g_sat * g_sat;

   assign stat.n_eff     = n_eff;
   assign stat.in_window = (locus_position >= ws_ff) &&
                           ({1'b0, locus_position} + 33'd1 < {1'b0, ws_ff} + 33'(wsz_ff));
   assign stat.sxy_busy  = v1_ff || v2_ff;
   assign stat.v_bad     = ($signed(vx_ff) <= 0) || ($signed(vy_ff) <= 0);
   assign stat.num_ge_den = (num_ff >= den_ff);

   assign sum_upd = (cmd.row_start ? '0 : cur_sum_ff) +
                    (cmd.item_go ? SUM_W'(g_sat) : '0);
   assign sq_upd  = (cmd.row_start ? '0 : cur_sq_ff) +
                    (cmd.item_go ? SQ_W'(g_sq) : '0);

   always_ff @(posedge clock) begin
      if (cmd.item_go) begin
         geno_mem[{cmd.wr_row, cmd.wr_idx}] <= g_sat;
      end else if (cmd.fill_go) begin
         geno_mem[{cmd.wr_row, cmd.wr_idx}] <= '0;
      end
      rda_ff <= geno_mem[{cmd.rd_a, cmd.rd_idx}];
      rdb_ff <= geno_mem[{cmd.rd_b, cmd.rd_idx}];
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         sum_mem[cmd.wr_row] <= sum_upd;
         sq_mem[cmd.wr_row]  <= sq_upd;
      end
      sa_ff  <= sum_mem[cmd.rd_a];
      sb_ff  <= sum_mem[cmd.rd_b];
      saa_ff <= sq_mem[cmd.rd_a];
      sbb_ff <= sq_mem[cmd.rd_b];
   end

   always_ff @(posedge clock) begin
      if (cmd.cur_upd) begin
         cur_sum_ff <= sum_upd;
         cur_sq_ff  <= sq_upd;
      end
   end

   // cross-product pipeline: read, multiply, accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.rd_go;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      pxy_ff <= rda_ff * rdb_ff;
      if (cmd.sxy_clr) begin
         sxy_ff <= '0;
      end else if (v2_ff) begin
         sxy_ff <= sxy_ff + SXY_W'(pxy_ff);
      end
   end

   assign opa = pick(cmd.uop.opa, n_eff, saa_ff, sbb_ff, sxy_ff, sa_ff, sb_ff, cm_ff,
                     vx_ff, vy_ff);
   assign opb = pick(cmd.uop.opb, n_eff, saa_ff, sbb_ff, sxy_ff, sa_ff, sb_ff, cm_ff,
                     vx_ff, vy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         uop_v_ff <= 1'b0;
      end else begin
         uop_v_ff <= cmd.uop_go;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= opa * opb;
      uop_d_ff <= cmd.uop;
   end

   always_comb begin
      acc_base = uop_d_ff.clr ? '0 : acc_ff;
      case (uop_d_ff.sh)
         SH_24:   prod_sh = {{(ACC_W-PROD_W-24){1'b0}}, prod_ff, 24'd0};
         SH_48:   prod_sh = {prod_ff, 48'd0};
         default: prod_sh = ACC_W'(prod_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (uop_v_ff && uop_d_ff.mul) begin
         acc_ff <= uop_d_ff.sub ? acc_base - prod_sh : acc_base + prod_sh;
      end
      if (uop_v_ff) begin
         case (uop_d_ff.dst)
            DST_VX:  vx_ff  <= acc_ff[V_W-1:0];
            DST_VY:  vy_ff  <= acc_ff[V_W-1:0];
            DST_CM:  cm_ff  <= acc_ff[V_W-1] ? (~acc_ff[V_W-1:0] + 1'b1) : acc_ff[V_W-1:0];
            DST_NUM: num_ff <= acc_ff;
            DST_DEN: den_ff <= acc_ff;
            default: ;
         endcase
      end
   end

   // restoring divider, one quotient bit per step
   assign trial  = {rem_ff[ACC_W-2:0], dvd_ff[ACC_W-1]};
   assign s_prod = cmd.snp * (cmd.snp - 1'b1);

   always_ff @(posedge clock) begin
      if (cmd.div_r2_start) begin
         rem_ff <= num_ff;
         dvd_ff <= '0;
         dsr_ff <= den_ff;
         quo_ff <= '0;
      end else if (cmd.div_mean_start) begin
         rem_ff <= '0;
         dvd_ff <= {tot_ff, {(ACC_W-TOT_W){1'b0}}};
         dsr_ff <= ACC_W'(pairs_ff);
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[ACC_W-2:0], 1'b0};
         if (trial >= dsr_ff) begin
            rem_ff <= trial - dsr_ff;
            quo_ff <= {quo_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[Q_W-2:0], 1'b0};
         end
      end
      if (cmd.pairs_load) begin
         pairs_ff <= PAIRS_W'(s_prod >> 1);
      end
      if (cmd.tot_clr) begin
         tot_ff <= '0;
      end else if (cmd.tot_add_one) begin
         tot_ff <= tot_ff + TOT_W'(ONE_Q16);
      end else if (cmd.tot_add_q) begin
         tot_ff <= tot_ff + TOT_W'(quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         window_valid    <= cmd.out_win;
         snp_count       <= cmd.snp;
         mean_r_squared  <= cmd.out_win ? quo_ff : '0;
         degenerate_pair <= cmd.out_deg;
         locus_overflow  <= cmd.out_ovf;
      end
   end

endmodule

// ===== sv/windowed_mean_pairwise_r2.sv =====
// Loading takes one genotype transaction per cycle except during padding. A locus that
// closes with fewer values than num_individuals stalls the input while the row is
// padded with zeros. After last_of_set, a window of more than four loci is reduced
// pair by pair through one shared 24x24 multiplier and a bit-serial divider: each pair
// takes n reads of the two genotype rows, the multiplier micro-ops and 16 divider steps;
// a zero-variance pair skips the second micro-op pass and divider. The mean then takes
// 28 more divider steps. No input is taken from last_of_set until the result register
// is loaded. Top level: instantiates wmr2_ctrl and wmr2_dp; uses wmr2_pkg, wmr2_if.
module windowed_mean_pairwise_r2 import wmr2_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   wmr2_req_if.sink              req_ch,
   wmr2_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   wmr2_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_last_of_locus (req_ch.last_of_locus),
      .req_last_of_set   (req_ch.last_of_set),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .cmd               (cmd),
      .stat              (stat)
   );

   wmr2_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .locus_position  (req_ch.locus_position),
      .genotype_value  (req_ch.genotype_value),
      .cmd             (cmd),
      .stat            (stat),
      .window_valid    (rsp_ch.window_valid),
      .snp_count       (rsp_ch.snp_count),
      .mean_r_squared  (rsp_ch.mean_r_squared),
      .degenerate_pair (rsp_ch.degenerate_pair),
      .locus_overflow  (rsp_ch.locus_overflow)
   );

endmodule
